// ----- rtl/case_insensitive_substring_search_core_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the case-insensitive substring search core
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CASE_INSENSITIVE_SUBSTRING_SEARCH_CORE_DEFINES_SVH
`define CASE_INSENSITIVE_SUBSTRING_SEARCH_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CIS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CIS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/cis_pkg.sv -----
// ----------------------------------------------------------------------------
// Case-insensitive substring search package
// Shared widths, register indexes and the ASCII case-folding function.
// ----------------------------------------------------------------------------
package cis_pkg;

    // Default and largest supported needle length in characters.
    localparam int NEEDLE_MAX_DEFAULT = 16;

    // Field widths.
    localparam int CHAR_W     = 8;
    localparam int LEN_W      = 5;
    localparam int OFFSET_W   = 16;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;

    // Number of characters packed into one needle word.
    localparam int CHARS_PER_WORD = CFG_DATA_W / CHAR_W;

    // Saturation value of the character offset.
    localparam logic [OFFSET_W-1:0] OFFSET_MAX = '1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NEEDLE_LENGTH = 2'd0,
        CFG_NEEDLE_LOW    = 2'd1,
        CFG_NEEDLE_HIGH   = 2'd2
    } cfg_reg_t;

    // Fold ASCII upper case letters to lower case; other bytes pass unchanged.
    function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

// ----- rtl/case_insensitive_substring_search_core.sv -----
// ----------------------------------------------------------------------------
// Case-insensitive substring search core
// Streams a haystack one character per transfer and reports the first
// occurrence of the configured needle at the end of each string.
// ----------------------------------------------------------------------------
// Usage:
// The needle is loaded through the write port (cfg_we, cfg_index, cfg_data)
// while the core is idle: index 0 sets the length, 1 and 2 the characters.
// Haystack items arrive on the in channel (in_valid/in_ready), one character
// per transfer; char_valid low marks an empty string, end_of_string the last
// item of a string. Each item with end_of_string gives one result on the out
// channel (out_valid/out_ready): found and match_start.
// Every item is handled in the cycle it is accepted, so a result appears in
// the cycle after its last transfer; the core takes one item every cycle
// unless a result is stalled. The output register frees in the cycle its
// result is taken; while the receiver stalls it, in_ready drops and input waits.
// Reset clears the needle to empty and the search state to a fresh string;
// there is no clearing pass, so items are accepted straight after reset.
// ----------------------------------------------------------------------------
`include "case_insensitive_substring_search_core_defines.svh"

module case_insensitive_substring_search_core #(
    parameter int NEEDLE_MAX = cis_pkg::NEEDLE_MAX_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration write port
    input  logic                              cfg_we,
    input  logic [cis_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cis_pkg::CFG_DATA_W-1:0]    cfg_data,
    // Haystack input channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [cis_pkg::CHAR_W-1:0]        hay_char,
    input  logic                              char_valid,
    input  logic                              end_of_string,
    // Result channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              found,
    output logic [cis_pkg::OFFSET_W-1:0]      match_start
);
    import cis_pkg::*;

    // Configuration state.
    logic [LEN_W-1:0]                  needle_len_reg;
    logic [NEEDLE_MAX-1:0][CHAR_W-1:0] needle_reg;
    logic [LEN_W-1:0]                  eff_len;

    // Search state.
    logic [NEEDLE_MAX-1:0] pmv_reg, pmv_next;
    logic [OFFSET_W-1:0]   offset_reg, offset_next;
    logic                  seen_reg, seen_next;
    logic [OFFSET_W-1:0]   first_reg, first_next;

    // Result register.
    logic                  out_valid_reg, out_valid_next;
    logic                  found_reg, found_next;
    logic [OFFSET_W-1:0]   start_reg, start_next;

    // Match unit outputs.
    logic [NEEDLE_MAX-1:0] unit_pmv;
    logic                  unit_hit;

    logic in_fire;
    logic len_zero;

    // Length register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            needle_len_reg <= '0;
        end
        else if (cfg_we && cfg_reg_t'(cfg_index) == CFG_NEEDLE_LENGTH)
        begin
            needle_len_reg <= cfg_data[LEN_W-1:0];
        end
    end

    // Needle characters, stored folded; each comes from the low or high word.
    for (genvar g = 0; g < NEEDLE_MAX; g++)
    begin : g_needle
        localparam int        SLOT = g % CHARS_PER_WORD;
        localparam cfg_reg_t  SRC  = (g < CHARS_PER_WORD) ? CFG_NEEDLE_LOW
                                                          : CFG_NEEDLE_HIGH;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                needle_reg[g] <= '0;
            end
            else if (cfg_we && cfg_reg_t'(cfg_index) == SRC)
            begin
                needle_reg[g] <= fold_char(cfg_data[SLOT*CHAR_W +: CHAR_W]);
            end
        end
    end

    // Needle length clamped to the supported maximum.
    always_comb
    begin
        if (needle_len_reg > LEN_W'(NEEDLE_MAX))
        begin
            eff_len = LEN_W'(NEEDLE_MAX);
        end
        else
        begin
            eff_len = needle_len_reg;
        end
    end

    assign len_zero = (eff_len == '0);

    // Parallel compare and shift-and step.
    cis_match_unit #(
        .NEEDLE_MAX (NEEDLE_MAX)
    ) u_match (
        .needle_chars (needle_reg),
        .hay_char     (hay_char),
        .eff_len      (eff_len),
        .pmv          (pmv_reg),
        .pmv_next     (unit_pmv),
        .hit          (unit_hit)
    );

    // Input is taken whenever the result register is free or being emptied.
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    // Next search state and result for an accepted transfer.
    always_comb
    begin
        pmv_next       = pmv_reg;
        offset_next    = offset_reg;
        seen_next      = seen_reg;
        first_next     = first_reg;
        found_next     = found_reg;
        start_next     = start_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (in_fire)
        begin
            // Advance partial matches and record the first full match.
            if (char_valid && !len_zero)
            begin
                pmv_next = unit_pmv;
                if (!seen_reg && unit_hit)
                begin
                    seen_next  = 1'b1;
                    first_next = offset_reg - OFFSET_W'(eff_len) + OFFSET_W'(1);
                end
            end

            // Saturating character offset.
            if (char_valid && offset_reg != OFFSET_MAX)
            begin
                offset_next = offset_reg + OFFSET_W'(1);
            end

            // End of string: load the result and start a fresh search.
            if (end_of_string)
            begin
                out_valid_next = 1'b1;
                if (len_zero)
                begin
                    found_next = 1'b1;
                    start_next = '0;
                end
                else if (seen_next)
                begin
                    found_next = 1'b1;
                    start_next = first_next;
                end
                else
                begin
                    found_next = 1'b0;
                    start_next = '0;
                end
                pmv_next    = '0;
                offset_next = '0;
                seen_next   = 1'b0;
                first_next  = '0;
            end
        end
    end

    // Search state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pmv_reg    <= '0;
            offset_reg <= '0;
            seen_reg   <= 1'b0;
            first_reg  <= '0;
        end
        else
        begin
            pmv_reg    <= pmv_next;
            offset_reg <= offset_next;
            seen_reg   <= seen_next;
            first_reg  <= first_next;
        end
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        found_reg <= found_next;
        start_reg <= start_next;
    end

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign match_start = start_reg;

    // A result that reports no match carries a zero offset.
    `CIS_ASSERT_SAME(a_notfound_zero, out_valid_reg && !found_reg, start_reg == '0,
        "result without a match has a non-zero offset")

    // An empty needle always reports a match at offset zero.
    `CIS_ASSERT_NEXT(a_empty_needle, in_fire && end_of_string && len_zero,
        out_valid_reg && found_reg && start_reg == '0,
        "empty needle did not report a match at offset zero")

    // The end of a string leaves a clean search state behind.
    `CIS_ASSERT_NEXT(a_clear_after_end, in_fire && end_of_string,
        pmv_reg == '0 && offset_reg == '0 && !seen_reg && first_reg == '0,
        "search state not cleared after end of string")

    // The recorded start is only non-zero once a match has been seen.
    `CIS_ASSERT_SAME(a_first_needs_seen, !seen_reg, first_reg == '0,
        "first match offset set without a recorded match")

endmodule

// ----- rtl/cis_match_unit.sv -----
// ----------------------------------------------------------------------------
// Case-insensitive substring search match unit
// Compares one haystack character with every needle character in parallel and
// advances the shift-and partial match vector.
// ----------------------------------------------------------------------------
module cis_match_unit #(
    parameter int NEEDLE_MAX = cis_pkg::NEEDLE_MAX_DEFAULT
) (
    input  logic [NEEDLE_MAX-1:0][cis_pkg::CHAR_W-1:0] needle_chars,
    input  logic [cis_pkg::CHAR_W-1:0]                 hay_char,
    input  logic [cis_pkg::LEN_W-1:0]                  eff_len,
    input  logic [NEEDLE_MAX-1:0]                      pmv,
    output logic [NEEDLE_MAX-1:0]                      pmv_next,
    output logic                                       hit
);
    import cis_pkg::*;

    logic [CHAR_W-1:0]     hay_folded;
    logic [NEEDLE_MAX-1:0] eq_vec;
    logic [NEEDLE_MAX-1:0] top_mask;
    logic [NEEDLE_MAX-1:0] shifted;

    // Folded haystack character; the needle is stored already folded.
    assign hay_folded = fold_char(hay_char);

    // Per-position equality, limited to positions inside the needle, and the
    // one-hot marker of the last needle position.
    always_comb
    begin
        for (int i = 0; i < NEEDLE_MAX; i++)
        begin
            eq_vec[i]   = (needle_chars[i] == hay_folded) && (LEN_W'(i) < eff_len);
            top_mask[i] = (LEN_W'(i + 1) == eff_len);
        end
    end

    // Shift-and step: extend every partial match by one and start a new one.
    if (NEEDLE_MAX > 1)
    begin : g_shift
        assign shifted = {pmv[NEEDLE_MAX-2:0], 1'b1};
    end
    else
    begin : g_single
        assign shifted = 1'b1;
    end

    assign pmv_next = shifted & eq_vec;
    assign hit      = |(pmv_next & top_mask);

endmodule
